>>> hdl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared constants and arctangent table for the Cartesian to
// cylindrical/spherical converter.
// ----------------------------------------------------------------------------
package ccs_pkg;

   localparam int COORD_W     = 16;   // input coordinate width, Q8.8
   localparam int ANG_FRAC    = 13;   // output angle fraction bits
   localparam int CORDIC_ITER = 16;   // CORDIC micro-rotations
   localparam int SCALE_SHIFT = 32 - COORD_W;
   localparam int ACC_BITS    = 30;   // angle accumulator fraction bits
   localparam int AW          = 34;   // angle accumulator width
   localparam int CW          = 36;   // CORDIC x/y datapath width
   localparam int ANG_OUT_W   = AW - (ACC_BITS - ANG_FRAC);
   localparam int TAB_LEN     = 24;

   // root extraction: 64-bit radicand, two bits per stage
   localparam int SQ_N_W      = 64;
   localparam int SQ_Q_W      = 32;
   localparam int SQ_R_W      = 34;
   localparam int SQ_STAGES   = SQ_N_W / 2;

   localparam int CORDIC_LAT  = CORDIC_ITER + 2;
   localparam int PIPE_LAST   = 2 + SQ_STAGES + CORDIC_LAT;   // index of last stage
   localparam int SQ_OUT_IDX  = 2 + SQ_STAGES;

   localparam int RADIUS_W    = 16;
   localparam int POLAR_W     = 15;

   // atan(2^-i) * 2^30, rounded to nearest
   localparam logic signed [AW-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
      34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
      34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
      34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
      34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
      34'sd1024,      34'sd512,       34'sd256,       34'sd128
   };

endpackage

>>> hdl/ccs_isqrt.sv
// ----------------------------------------------------------------------------
// ccs_isqrt
// Pipelined restoring integer square root: one root bit per stage, floor
// root and remainder out of the last stage register, advancing on enable.
// ----------------------------------------------------------------------------
module ccs_isqrt import ccs_pkg::*; (
   input  logic              clock,
   input  logic              enable,
   input  logic [SQ_N_W-1:0] n_in,
   output logic [SQ_Q_W-1:0] root,
   output logic [SQ_R_W-1:0] rem
);

   logic [SQ_R_W-1:0] rem_ff  [1:SQ_STAGES];
   logic [SQ_Q_W-1:0] root_ff [1:SQ_STAGES];
   logic [SQ_N_W-1:0] n_ff    [1:SQ_STAGES];

   logic [SQ_R_W-1:0] rem_s  [0:SQ_STAGES];
   logic [SQ_Q_W-1:0] root_s [0:SQ_STAGES];
   logic [SQ_N_W-1:0] n_s    [0:SQ_STAGES];

   assign rem_s[0]  = '0;
   assign root_s[0] = '0;
   assign n_s[0]    = n_in;

   genvar k;
   generate
      for (k = 0; k < SQ_STAGES; k++) begin : g_stage
         logic [SQ_R_W+1:0] cur;
         logic [SQ_R_W+1:0] trial;
         logic [SQ_R_W+1:0] diff;
         logic              take;

         assign rem_s[k+1]  = rem_ff[k+1];
         assign root_s[k+1] = root_ff[k+1];
         assign n_s[k+1]    = n_ff[k+1];

         assign cur   = {rem_s[k], n_s[k][SQ_N_W-1 -: 2]};
         assign trial = {2'b00, root_s[k], 2'b01};
         assign take  = (cur >= trial);
         assign diff  = cur - trial;

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k+1]  <= take ? diff[SQ_R_W-1:0] : cur[SQ_R_W-1:0];
               root_ff[k+1] <= {root_s[k][SQ_Q_W-2:0], take};
               n_ff[k+1]    <= {n_s[k][SQ_N_W-3:0], 2'b00};
            end
         end
      end
   endgenerate

   assign root = root_s[SQ_STAGES];
   assign rem  = rem_s[SQ_STAGES];

endmodule

>>> hdl/ccs_cordic.sv
// ----------------------------------------------------------------------------
// ccs_cordic
// Pipelined vectoring CORDIC giving atan2(y, x): quadrant pre-rotation,
// one micro-rotation per stage, then rounding to ANG_FRAC fraction bits.
// ----------------------------------------------------------------------------
module ccs_cordic import ccs_pkg::*; (
   input  logic                        clock,
   input  logic                        enable,
   input  logic signed [CW-1:0]        x_in,
   input  logic signed [CW-1:0]        y_in,
   output logic signed [ANG_OUT_W-1:0] angle
);

   localparam int RND_SHIFT = ACC_BITS - ANG_FRAC;

   logic signed [CW-1:0]        x_ff   [0:CORDIC_ITER];
   logic signed [CW-1:0]        y_ff   [0:CORDIC_ITER];
   logic signed [AW-1:0]        ang_ff [0:CORDIC_ITER];
   logic signed [ANG_OUT_W-1:0] angle_ff;
   logic signed [AW-1:0]        ang_rnd;

   // left half plane: rotate by +-pi/2 first
   always_ff @(posedge clock) begin
      if (enable) begin
         if (x_in < 0) begin
            if (y_in >= 0) begin
               x_ff[0]   <= y_in;
               y_ff[0]   <= -x_in;
               ang_ff[0] <= ATAN_TAB[0] <<< 1;
            end else begin
               x_ff[0]   <= -y_in;
               y_ff[0]   <= x_in;
               ang_ff[0] <= -(ATAN_TAB[0] <<< 1);
            end
         end else begin
            x_ff[0]   <= x_in;
            y_ff[0]   <= y_in;
            ang_ff[0] <= '0;
         end
      end
   end

   genvar i;
   generate
      for (i = 0; i < CORDIC_ITER; i++) begin : g_iter
         logic signed [CW-1:0] dx;
         logic signed [CW-1:0] dy;
         assign dx = y_ff[i] >>> i;
         assign dy = x_ff[i] >>> i;
         always_ff @(posedge clock) begin
            if (enable) begin
               if (y_ff[i] > 0) begin
                  x_ff[i+1]   <= x_ff[i] + dx;
                  y_ff[i+1]   <= y_ff[i] - dy;
                  ang_ff[i+1] <= ang_ff[i] + ATAN_TAB[i];
               end else begin
                  x_ff[i+1]   <= x_ff[i] - dx;
                  y_ff[i+1]   <= y_ff[i] + dy;
                  ang_ff[i+1] <= ang_ff[i] - ATAN_TAB[i];
               end
            end
         end
      end
   endgenerate

   assign ang_rnd = ang_ff[CORDIC_ITER] + (AW'(1) <<< (RND_SHIFT - 1));

   always_ff @(posedge clock) begin
      if (enable) begin
         angle_ff <= ANG_OUT_W'(ang_rnd >>> RND_SHIFT);
      end
   end

   assign angle = angle_ff;

endmodule

>>> hdl/cartesian_to_cylindrical_spherical.sv
// ----------------------------------------------------------------------------
// cartesian_to_cylindrical_spherical
// Converts a Q8.8 point to cylindrical (rho, phi, z) or spherical (r, phi,
// theta) form; azimuth Q3.13 and polar Q2.13 radians from pipelined CORDICs.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   x, y, z coords (Q8.8 signed)
//  rsp       out        rsp_valid/rsp_stall   radius, azimuth, height, polar, flag
//  csr       in/out     APB psel/penable      coordinate_mode at address 0
//
//  One item per cycle while the result is not stalled; from accept to rsp_valid
//  a point passes 2 stages of squares and sums, the 32-stage square root,
//  the 18-stage polar-angle CORDIC and the result register.
//  Reset clears valid bits and coordinate_mode (cylindrical).
//  A stalled result freezes the whole pipeline; req_stall follows it.
// ----------------------------------------------------------------------------
module cartesian_to_cylindrical_spherical import ccs_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [COORD_W-1:0]   req_x_coord,
   input  logic signed [COORD_W-1:0]   req_y_coord,
   input  logic signed [COORD_W-1:0]   req_z_coord,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [RADIUS_W-1:0]         rsp_radius,
   output logic signed [COORD_W-1:0]   rsp_azimuth,
   output logic signed [COORD_W-1:0]   rsp_height,
   output logic [POLAR_W-1:0]          rsp_polar_angle,
   output logic                        rsp_angle_undefined,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [1:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      mode;
   } side_type;

   logic                      mode_ff;
   logic                      adv;
   logic                      valid_ff [0:PIPE_LAST];
   side_type                  side_ff  [0:PIPE_LAST];
   logic [2*COORD_W-1:0]      sqx_ff, sqy_ff, sqz_ff;
   logic [SQ_Q_W-1:0]         planar_ff;
   logic [SQ_Q_W-1:0]         nrad_ff;
   logic [RADIUS_W-1:0]       rad_ff   [0:CORDIC_LAT-1];
   logic signed [2*COORD_W-1:0] sqx_s, sqy_s, sqz_s;
   logic [SQ_Q_W-1:0]         planar_in;

   logic [SQ_Q_W-1:0]         rad_root, rho_root;
   logic [SQ_R_W-1:0]         rad_rem, rho_rem;
   logic [SQ_Q_W:0]           rad_up;
   logic [RADIUS_W-1:0]       rad_in;
   logic signed [CW-1:0]      az_x, az_y, po_x, po_y;
   logic signed [ANG_OUT_W-1:0] az_ang, po_ang;

   side_type                  last;
   logic                      undef;

   logic                      rsp_valid_ff;
   logic [RADIUS_W-1:0]       rsp_radius_ff;
   logic signed [COORD_W-1:0] rsp_azimuth_ff, rsp_height_ff;
   logic [POLAR_W-1:0]        rsp_polar_ff;
   logic                      rsp_undef_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = {31'b0, mode_ff};

   // ---------------- pipeline control ----------------
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= PIPE_LAST; k++) valid_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k <= PIPE_LAST; k++) valid_ff[k] <= valid_ff[k-1];
         rsp_valid_ff <= valid_ff[PIPE_LAST];
      end
   end

   // coordinates and mode travel alongside the math
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{x: req_x_coord, y: req_y_coord, z: req_z_coord, mode: mode_ff};
         for (int k = 1; k <= PIPE_LAST; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   // ---------------- squares and sums ----------------
   assign sqx_s = side_ff[0].x * side_ff[0].x;
   assign sqy_s = side_ff[0].y * side_ff[0].y;
   assign sqz_s = side_ff[0].z * side_ff[0].z;
   assign planar_in = sqx_ff + sqy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff    <= sqx_s;
         sqy_ff    <= sqy_s;
         sqz_ff    <= sqz_s;
         planar_ff <= planar_in;
         nrad_ff   <= side_ff[1].mode ? (planar_in + sqz_ff) : planar_in;
      end
   end

   // ---------------- square roots ----------------
   ccs_isqrt u_rad_sqrt (
      .clock  (clock),
      .enable (adv),
      .n_in   ({{(SQ_N_W-SQ_Q_W){1'b0}}, nrad_ff}),
      .root   (rad_root),
      .rem    (rad_rem)
   );

   // planar radius scaled by 2^SCALE_SHIFT for the polar CORDIC
   ccs_isqrt u_rho_sqrt (
      .clock  (clock),
      .enable (adv),
      .n_in   ({planar_ff, {(SQ_N_W-SQ_Q_W){1'b0}}}),
      .root   (rho_root),
      .rem    (rho_rem)
   );

   // round half up: remainder above root means n is past (q + 0.5)^2
   assign rad_up = {1'b0, rad_root} + (SQ_Q_W+1)'(({2'b0, rad_root} < rad_rem) ? 1 : 0);
   assign rad_in = (rad_up > (SQ_Q_W+1)'({RADIUS_W{1'b1}})) ? {RADIUS_W{1'b1}}
                                                            : rad_up[RADIUS_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff[0] <= rad_in;
         for (int k = 1; k < CORDIC_LAT; k++) rad_ff[k] <= rad_ff[k-1];
      end
   end

   // ---------------- angles ----------------
   assign az_x = CW'(side_ff[SQ_OUT_IDX].x) <<< SCALE_SHIFT;
   assign az_y = CW'(side_ff[SQ_OUT_IDX].y) <<< SCALE_SHIFT;
   assign po_x = CW'(side_ff[SQ_OUT_IDX].z) <<< SCALE_SHIFT;
   assign po_y = {{(CW-SQ_Q_W){1'b0}}, rho_root};

   ccs_cordic u_azimuth (
      .clock  (clock),
      .enable (adv),
      .x_in   (az_x),
      .y_in   (az_y),
      .angle  (az_ang)
   );

   ccs_cordic u_polar (
      .clock  (clock),
      .enable (adv),
      .x_in   (po_x),
      .y_in   (po_y),
      .angle  (po_ang)
   );

   // ---------------- result register ----------------
   assign last  = side_ff[PIPE_LAST];
   assign undef = (last.x == '0) && (last.y == '0);

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_radius_ff  <= rad_ff[CORDIC_LAT-1];
         rsp_azimuth_ff <= undef ? '0 : COORD_W'(az_ang);
         rsp_height_ff  <= last.mode ? '0 : last.z;
         if (last.mode && !(undef && last.z == '0) && !po_ang[ANG_OUT_W-1]) begin
            rsp_polar_ff <= po_ang[POLAR_W-1:0];
         end else begin
            rsp_polar_ff <= '0;
         end
         rsp_undef_ff   <= undef;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_radius          = rsp_radius_ff;
   assign rsp_azimuth         = rsp_azimuth_ff;
   assign rsp_height          = rsp_height_ff;
   assign rsp_polar_angle     = rsp_polar_ff;
   assign rsp_angle_undefined = rsp_undef_ff;

   // ---------------- assertions ----------------
   a_undef_azimuth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_undef_ff |-> rsp_azimuth_ff == '0)
      else $error("azimuth not zero on undefined angle");

   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_radius_ff == '0 |-> rsp_undef_ff)
      else $error("zero radius without undefined flag");

   a_height_polar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_height_ff != '0 |-> rsp_polar_ff == '0)
      else $error("height and polar angle both set");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_radius_ff)
                                    && $stable(valid_ff[PIPE_LAST]))
      else $error("pipeline moved while result stalled");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Cartesian to cylindrical/spherical converter.
// Directed corner points in both modes, mode register access, then random
// points, idle/stall bursts in most runs, checked by an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import ccs_pkg::*;

   typedef struct packed {
      logic [RADIUS_W-1:0]       radius;
      logic signed [COORD_W-1:0] azimuth;
      logic signed [COORD_W-1:0] height;
      logic [POLAR_W-1:0]        polar;
      logic                      undef;
   } coords_type;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [COORD_W-1:0] req_x_coord = '0, req_y_coord = '0, req_z_coord = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [RADIUS_W-1:0] rsp_radius;
   logic signed [COORD_W-1:0] rsp_azimuth, rsp_height;
   logic [POLAR_W-1:0] rsp_polar_angle;
   logic rsp_angle_undefined;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   coords_type pending_coords[$];
   bit      spherical_mode = 1'b0;
   bit      idle_enable = 1'b0;
   int      error_count = 0;
   int      quiet_cycles = 0;
   int      stall_left = 0;

   cartesian_to_cylindrical_spherical DUT (.*);

   always #10 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned root_nearest(longint unsigned n);
      longint unsigned q;
      q = root_floor(n);
      if (n - q * q > q) q++;
      return q;
   endfunction

   function automatic longint vector_angle(longint x, longint y);
      longint ang, t, dx, dy;
      ang = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t;
            ang = 2 * longint'(ATAN_TAB[0]);
         end else begin
            t = x; x = -y; y = t;
            ang = -2 * longint'(ATAN_TAB[0]);
         end
      end
      for (int i = 0; i < CORDIC_ITER; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; ang += longint'(ATAN_TAB[i]);
         end else begin
            x -= dx; y += dy; ang -= longint'(ATAN_TAB[i]);
         end
      end
      ang += longint'(1) << (ACC_BITS - ANG_FRAC - 1);
      return ang >>> (ACC_BITS - ANG_FRAC);
   endfunction

   function automatic coords_type convert_point(logic signed [COORD_W-1:0] xi,
                                                logic signed [COORD_W-1:0] yi,
                                                logic signed [COORD_W-1:0] zi);
      coords_type r;
      longint x, y, z, p;
      longint unsigned ax, ay, az, planar2, rad, rho;
      x = longint'(xi); y = longint'(yi); z = longint'(zi);
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      planar2 = ax * ax + ay * ay;
      r = '0;
      r.undef = (x == 0 && y == 0);
      if (!r.undef)
         r.azimuth = COORD_W'(vector_angle(x <<< SCALE_SHIFT, y <<< SCALE_SHIFT));
      if (spherical_mode) begin
         rad = root_nearest(planar2 + az * az);
         if (!(r.undef && z == 0)) begin
            rho = root_floor(planar2 << (2 * SCALE_SHIFT));
            p = vector_angle(z <<< SCALE_SHIFT, longint'(rho));
            r.polar = p < 0 ? '0 : p[POLAR_W-1:0];
         end
      end else begin
         rad = root_nearest(planar2);
         r.height = zi;
      end
      r.radius = rad > 65535 ? 16'hFFFF : rad[RADIUS_W-1:0];
      return r;
   endfunction

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      coords_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_coords.size() == 0) begin
            $error("unexpected result item");
            error_count++;
         end else begin
            e = pending_coords.pop_front();
            if (rsp_radius !== e.radius) begin
               $error("radius exp %0d got %0d", e.radius, rsp_radius); error_count++;
            end
            if (rsp_azimuth !== e.azimuth) begin
               $error("azimuth exp %0d got %0d", e.azimuth, rsp_azimuth); error_count++;
            end
            if (rsp_height !== e.height) begin
               $error("height exp %0d got %0d", e.height, rsp_height); error_count++;
            end
            if (rsp_polar_angle !== e.polar) begin
               $error("polar_angle exp %0d got %0d", e.polar, rsp_polar_angle);
               error_count++;
            end
            if (rsp_angle_undefined !== e.undef) begin
               $error("angle_undefined exp %0d got %0d", e.undef, rsp_angle_undefined);
               error_count++;
            end
         end
      end
   end

   // receiver stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                             logic signed [COORD_W-1:0] z);
      int gap;
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      req_z_coord <= z;
      do @(posedge clock); while (req_stall);
      pending_coords.push_back(convert_point(x, y, z));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_coords.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= 2'd0; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      spherical_mode = value[0];
   endtask

   task automatic check_mode_readback();
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b0; csr_paddr <= 2'd0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[0] !== spherical_mode) begin
         $error("coordinate_mode exp %0d got %0d", spherical_mode, csr_prdata[0]);
         error_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0;
   endtask

   task automatic send_corner_points();
      send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_point(-16'sh8000, -16'sh8000, -16'sh8000);
      send_point(16'sh0000, 16'sh0000, 16'sh0000);
      send_point(16'sh0000, 16'sh0000, 16'sh0100);
      send_point(16'sh0000, 16'sh0000, -16'sh8000);
      send_point(-16'sh0100, 16'sh0000, 16'sh0001);
      send_point(-16'sh0100, -16'sh0001, -16'sh0001);
      send_point(16'sh0001, 16'sh0000, 16'sh0000);
      send_point(16'sh0000, -16'sh0001, 16'sh7FFF);
      send_point(-16'sh8000, 16'sh7FFF, 16'sh0000);
      send_point(16'sh0003, 16'sh0004, 16'sh000C);
   endtask

   task automatic test_directed_cylindrical();
      write_mode(32'd0);
      send_corner_points();
      drain_results();
   endtask

   task automatic test_directed_spherical();
      write_mode(32'd1);
      check_mode_readback();
      send_corner_points();
      drain_results();
   endtask

   task automatic test_mode_register();
      // only bit 0 is kept
      write_mode(32'hFFFF_FFFE);
      check_mode_readback();
      write_mode(32'hFFFF_FFFF);
      check_mode_readback();
      write_mode(32'h0000_0000);
      check_mode_readback();
   endtask

   task automatic test_random(int count, bit mode, bit with_idle);
      logic signed [COORD_W-1:0] c[3];
      write_mode({31'd0, mode});
      idle_enable = with_idle;
      repeat (count) begin
         foreach (c[k]) begin
            case ($urandom_range(0, 4))
               0: c[k] = COORD_W'($urandom_range(0, 1023) - 512);
               1: c[k] = '0;
               default: c[k] = COORD_W'($urandom);
            endcase
         end
         send_point(c[0], c[1], c[2]);
      end
      idle_enable = 1'b0;
      drain_results();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      check_mode_readback();
      test_directed_cylindrical();
      test_directed_spherical();
      test_mode_register();
      test_random(250, 1'b0, 1'b1);
      test_random(250, 1'b1, 1'b1);
      test_random(200, 1'b0, 1'b1);
      test_random(150, 1'b1, 1'b1);
      test_random(75, 1'b0, 1'b0);
      test_random(75, 1'b1, 1'b0);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
